@@ hw/rtl/ppcs_pkg.sv @@
package ppcs_pkg;

   localparam int PERIOD_MS_DEF   = 40;
   localparam int SETTLE_BAND_DEF = 32;
   localparam int ERROR_WIDTH_DEF = 16;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [15:0] SETTLE_WAIT_MIN = 16'd200;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET_TICKS   = 3'd0,
      CSR_REVERSE_MODE   = 3'd1,
      CSR_PROP_GAIN      = 3'd2,
      CSR_INTEG_GAIN     = 3'd3,
      CSR_INTEG_ZONE     = 3'd4,
      CSR_WINDUP_LIMIT   = 3'd5,
      CSR_POWER_LIMIT    = 3'd6,
      CSR_SETTLE_WAIT_MS = 3'd7
   } csr_index_type;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_TICK  = 1'b1;

   typedef struct packed {
      logic               action;
      logic signed [15:0] encoder_count;
   } req_type;

   typedef struct packed {
      logic signed [7:0]  drive_power;
      logic               move_done;
      logic signed [15:0] position_error;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] target_ticks;
      logic               reverse_mode;
      logic [15:0]        prop_gain;
      logic [15:0]        integ_gain;
      logic [14:0]        integ_zone;
      logic [14:0]        windup_limit;
      logic [6:0]         power_limit;
      logic [15:0]        settle_wait_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      target_ticks   : 16'sd0,
      reverse_mode   : 1'b0,
      prop_gain      : 16'd256,
      integ_gain     : 16'd1966,
      integ_zone     : 15'd86,
      windup_limit   : 15'd1666,
      power_limit    : 7'd127,
      settle_wait_ms : 16'd200
   };

endpackage

@@ hw/rtl/ppcs_csr.sv @@
module ppcs_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ppcs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ppcs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output ppcs_pkg::cfg_type                  cfg
);

   ppcs_pkg::cfg_type cfg_ff;
   ppcs_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (ppcs_pkg::csr_index_type'(csr_index))
            ppcs_pkg::CSR_TARGET_TICKS:   cfg_in.target_ticks = $signed(csr_wdata);
            ppcs_pkg::CSR_REVERSE_MODE:   cfg_in.reverse_mode = csr_wdata[0];
            ppcs_pkg::CSR_PROP_GAIN:      cfg_in.prop_gain    = csr_wdata;
            ppcs_pkg::CSR_INTEG_GAIN:     cfg_in.integ_gain   = csr_wdata;
            ppcs_pkg::CSR_INTEG_ZONE:     cfg_in.integ_zone   = csr_wdata[14:0];
            ppcs_pkg::CSR_WINDUP_LIMIT:   cfg_in.windup_limit = csr_wdata[14:0];
            ppcs_pkg::CSR_POWER_LIMIT:    cfg_in.power_limit  = csr_wdata[6:0];
            ppcs_pkg::CSR_SETTLE_WAIT_MS: begin
               // short waits are raised to the minimum
               cfg_in.settle_wait_ms = (csr_wdata < ppcs_pkg::SETTLE_WAIT_MIN) ?
                                       ppcs_pkg::SETTLE_WAIT_MIN : csr_wdata;
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ppcs_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/ppcs_track.sv @@
module ppcs_track #(
   parameter int PeriodMs   = ppcs_pkg::PERIOD_MS_DEF,
   parameter int SettleBand = ppcs_pkg::SETTLE_BAND_DEF,
   parameter int ErrorWidth = ppcs_pkg::ERROR_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  ppcs_pkg::req_type            req,
   input  ppcs_pkg::cfg_type            cfg,
   output logic signed [ErrorWidth-1:0] err,
   output logic signed [15:0]           sum,
   output logic                         done,
   output logic                         state_done
);

   localparam int DiffW = (ErrorWidth > 17) ? ErrorWidth + 1 : 18;
   localparam int SumW  = ((ErrorWidth > 16) ? ErrorWidth : 16) + 1;

   localparam logic signed [DiffW-1:0] ErrMax  = DiffW'((64'sd1 <<< (ErrorWidth - 1)) - 64'sd1);
   localparam logic signed [DiffW-1:0] ErrMin  = DiffW'(-(64'sd1 <<< (ErrorWidth - 1)));
   localparam logic signed [DiffW-1:0] BandX   = DiffW'(SettleBand);
   localparam logic [16:0]             PeriodX = 17'(PeriodMs);

   // controller state
   logic signed [15:0] integ_ff, integ_in;
   logic               settled_ff, settled_in;
   logic [15:0]        elapsed_ff, elapsed_in;
   logic               done_ff, done_in;

   // results handed to the drive stage
   logic signed [ErrorWidth-1:0] err_ff, err_in;
   logic signed [15:0]           sum_ff, sum_in;
   logic                         dout_ff, dout_in;

   logic signed [DiffW-1:0]      tgt_x, enc_x, pos_x, diff, err_sat, zone_x;
   logic signed [ErrorWidth-1:0] err_e;
   logic signed [SumW-1:0]       sum_x, err_x, sum_raw, lim_x, sum_clip;
   logic                         integ_en;
   logic                         settled_new;
   logic [16:0]                  elapsed_sum;
   logic [15:0]                  elapsed_new;
   logic                         done_new;

   always_comb begin
      tgt_x  = DiffW'(cfg.target_ticks);
      enc_x  = DiffW'(req.encoder_count);
      pos_x  = cfg.reverse_mode ? -enc_x : enc_x;
      diff   = tgt_x - pos_x;
      err_sat = (diff > ErrMax) ? ErrMax : ((diff < ErrMin) ? ErrMin : diff);
      err_e  = err_sat[ErrorWidth-1:0];

      zone_x   = $signed({{(DiffW-15){1'b0}}, cfg.integ_zone});
      integ_en = (err_sat != '0) && (err_sat < zone_x);
      sum_x    = SumW'(integ_ff);
      err_x    = SumW'(err_e);
      sum_raw  = integ_en ? (sum_x + err_x) : '0;
      lim_x    = $signed({{(SumW-15){1'b0}}, cfg.windup_limit});
      sum_clip = (sum_raw > lim_x) ? lim_x : ((sum_raw < -lim_x) ? -lim_x : sum_raw);

      // signed test: a large overshoot also counts as settled
      settled_new = settled_ff | (err_sat < BandX);
      elapsed_sum = {1'b0, elapsed_ff} + PeriodX;
      if (!settled_new) begin
         elapsed_new = '0;
      end else if (elapsed_sum[16]) begin
         elapsed_new = 16'hFFFF;
      end else begin
         elapsed_new = elapsed_sum[15:0];
      end
      done_new = (elapsed_new >= cfg.settle_wait_ms);
   end

   always_comb begin
      integ_in   = integ_ff;
      settled_in = settled_ff;
      elapsed_in = elapsed_ff;
      done_in    = done_ff;
      err_in     = err_ff;
      sum_in     = sum_ff;
      dout_in    = dout_ff;
      if (load) begin
         if (req.action == ppcs_pkg::ACT_START) begin
            integ_in   = '0;
            settled_in = 1'b0;
            elapsed_in = '0;
            done_in    = 1'b0;
            err_in     = '0;
            sum_in     = '0;
            dout_in    = 1'b0;
         end else if (!done_ff) begin
            integ_in   = sum_clip[15:0];
            settled_in = settled_new;
            elapsed_in = elapsed_new;
            done_in    = done_new;
            err_in     = err_e;
            sum_in     = sum_clip[15:0];
            dout_in    = done_new;
         end else begin
            // move finished: state frozen, only the error is reported
            err_in  = err_e;
            sum_in  = integ_ff;
            dout_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff   <= '0;
         settled_ff <= 1'b0;
         elapsed_ff <= '0;
         done_ff    <= 1'b0;
      end else begin
         integ_ff   <= integ_in;
         settled_ff <= settled_in;
         elapsed_ff <= elapsed_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff  <= err_in;
      sum_ff  <= sum_in;
      dout_ff <= dout_in;
   end

   assign err        = err_ff;
   assign sum        = sum_ff;
   assign done       = dout_ff;
   assign state_done = done_ff;

endmodule

@@ hw/rtl/ppcs_drive.sv @@
module ppcs_drive #(
   parameter int ErrorWidth = ppcs_pkg::ERROR_WIDTH_DEF
) (
   input  logic signed [ErrorWidth-1:0] err,
   input  logic signed [15:0]           sum,
   input  logic                         done,
   input  ppcs_pkg::cfg_type            cfg,
   output ppcs_pkg::rsp_type            rsp
);

   localparam int ProdW = ErrorWidth + 17;
   localparam int AccW  = ErrorWidth + 26;
   localparam int QW    = AccW - 16;
   localparam int PosW  = (ErrorWidth > 16) ? ErrorWidth : 16;

   localparam logic signed [AccW-1:0] RoundBias = AccW'(65535);
   localparam logic signed [PosW-1:0] PosMax    = PosW'(32767);
   localparam logic signed [PosW-1:0] PosMin    = PosW'(-32768);

   logic signed [ProdW-1:0] prod_p;
   logic signed [32:0]      prod_i;
   logic signed [AccW-1:0]  acc, biased;
   logic signed [QW-1:0]    quot, lim_q, power;
   logic signed [PosW-1:0]  err_w, err_16;

   always_comb begin
      prod_p = ProdW'($signed({1'b0, cfg.prop_gain})) * ProdW'(err);
      prod_i = 33'($signed({1'b0, cfg.integ_gain})) * 33'(sum);
      // accumulate in units of 2^-16
      acc    = (AccW'(prod_p) <<< 8) + AccW'(prod_i);
      // truncate toward zero
      biased = acc[AccW-1] ? (acc + RoundBias) : acc;
      quot   = biased[AccW-1:16];
      lim_q  = $signed({{(QW-7){1'b0}}, cfg.power_limit});
      power  = (quot > lim_q) ? lim_q : ((quot < -lim_q) ? -lim_q : quot);

      err_w  = PosW'(err);
      err_16 = (err_w > PosMax) ? PosMax : ((err_w < PosMin) ? PosMin : err_w);

      rsp.drive_power    = done ? 8'sd0 : power[7:0];
      rsp.move_done      = done;
      rsp.position_error = err_16[15:0];
   end

endmodule

@@ hw/rtl/pi_position_controller_settle_unit.sv @@
// PI position controller with integral zone, anti-windup clamp and settle timer.
// A start transaction (action 0) clears the integral, settle timer and done flag
// and returns zero power; each tick transaction (action 1) returns drive power,
// done flag and position error. The unit takes one transaction per clock unless a stall
// holds the pipeline and presents its result after passing three registers: the input
// register, the state-update register (error, integral and timer) and the result register
// behind the gain multipliers. Stall on the result side holds the pipeline and backs up
// to req_stall. The user must do register writes via the csr port while no
// transaction is in flight; the block does not enforce it. They take effect on the next tick.
module pi_position_controller_settle_unit #(
   parameter int PeriodMs   = ppcs_pkg::PERIOD_MS_DEF,
   parameter int SettleBand = ppcs_pkg::SETTLE_BAND_DEF,
   parameter int ErrorWidth = ppcs_pkg::ERROR_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  ppcs_pkg::req_type                req_payload,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ppcs_pkg::rsp_type                rsp_payload,

   input  logic                             csr_we,
   input  logic [ppcs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ppcs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   ppcs_pkg::cfg_type cfg;

   ppcs_pkg::req_type req_ff, req_in;
   logic              req_vld_ff, req_vld_in;
   logic              mid_vld_ff, mid_vld_in;
   ppcs_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_vld_ff, rsp_vld_in;

   logic                         take, adv1, adv2;
   logic signed [ErrorWidth-1:0] mid_err;
   logic signed [15:0]           mid_sum;
   logic                         mid_done;
   logic                         state_done;
   ppcs_pkg::rsp_type            rsp_calc;

   ppcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ppcs_track #(
      .PeriodMs   (PeriodMs),
      .SettleBand (SettleBand),
      .ErrorWidth (ErrorWidth)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .load       (adv1),
      .req        (req_ff),
      .cfg        (cfg),
      .err        (mid_err),
      .sum        (mid_sum),
      .done       (mid_done),
      .state_done (state_done)
   );

   ppcs_drive #(
      .ErrorWidth (ErrorWidth)
   ) u_drive (
      .err  (mid_err),
      .sum  (mid_sum),
      .done (mid_done),
      .cfg  (cfg),
      .rsp  (rsp_calc)
   );

   // pipeline flow: a stage moves when the next one is empty or moving
   always_comb begin
      adv2 = mid_vld_ff && (!rsp_vld_ff || !rsp_stall);
      adv1 = req_vld_ff && (!mid_vld_ff || adv2);
      take = !req_vld_ff || adv1;

      req_in     = take ? req_payload : req_ff;
      req_vld_in = take ? req_valid : req_vld_ff;
      mid_vld_in = adv1 ? 1'b1 : (adv2 ? 1'b0 : mid_vld_ff);
      rsp_in     = adv2 ? rsp_calc : rsp_ff;
      rsp_vld_in = adv2 ? 1'b1 : (rsp_stall ? rsp_vld_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         mid_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         mid_vld_ff <= mid_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall   = !take;
   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

   a_done_zero_power: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.move_done) |-> (rsp_ff.drive_power == 8'sd0))
      else $error("finished move reports nonzero drive power");

   a_power_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> ((rsp_ff.drive_power <= $signed({1'b0, cfg.power_limit}))
                   && (rsp_ff.drive_power >= -$signed({1'b0, cfg.power_limit}))))
      else $error("drive power outside the power limit");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (adv1 && state_done && (req_ff.action == ppcs_pkg::ACT_TICK)) |=> state_done)
      else $error("done state dropped without a start transaction");

endmodule
